// ===== hw/rtl/bpa_pkg.sv =====
// Shared types, codes and bit-search helpers for the bitmap page allocator.
package bpa_pkg;

  // Default number of managed pages.
  localparam int NUM_PAGES_DEFAULT = 65536;

  // Bits per map word and width of a bit index within a word.
  localparam int WORD_BITS = 64;
  localparam int BIT_W     = 6;

  // Operation codes.
  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_FREE    = 2'd1;
  localparam logic [1:0] OP_RESERVE = 2'd2;
  localparam logic [1:0] OP_RESET   = 2'd3;

  // Status codes.
  localparam logic [1:0] STAT_DONE     = 2'd0;
  localparam logic [1:0] STAT_NOFIT    = 2'd1;
  localparam logic [1:0] STAT_BADLEN   = 2'd2;
  localparam logic [1:0] STAT_NOCHANGE = 2'd3;

  // Controller states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_MSTART,
    ST_MARK,
    ST_SINGLE,
    ST_FILL,
    ST_DONE
  } state_t;

  // Index of the lowest set bit; zero when none is set.
  function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_BITS-1:0] x);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (x[i]) r = BIT_W'(i);
    end
    return r;
  endfunction

  // Count of set bits contiguous from bit 0 up.
  function automatic logic [BIT_W:0] run_from_low(input logic [WORD_BITS-1:0] x);
    logic [BIT_W:0] r;
    r = (BIT_W + 1)'(WORD_BITS);
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!x[i]) r = (BIT_W + 1)'(i);
    end
    return r;
  endfunction

  // Count of set bits contiguous from the top bit down.
  function automatic logic [BIT_W:0] run_from_high(input logic [WORD_BITS-1:0] x);
    logic [BIT_W:0] r;
    r = (BIT_W + 1)'(WORD_BITS);
    for (int i = 0; i < WORD_BITS; i++) begin
      if (!x[i]) r = (BIT_W + 1)'(WORD_BITS - 1 - i);
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/bitmap_page_allocator.sv =====
// Bitmap page allocator: first-fit run allocation over a used/free page map in block RAM.
//
// The page map sits in one 64-bit-wide synchronous RAM of NUM_PAGES/64 words. After reset the
// block sweeps the RAM to all-used, one word per cycle, and accepts no item until the sweep is
// done (configuration writes are taken throughout). An allocate scans the map one word per
// cycle up to the end of the first fitting run, then marks the words the run covers; one that
// finds no run stops at the end of the configured total or of the map, and a zero-length
// allocate responds without a scan. Free and reserve read the word, modify-write it and
// respond, and reset-map sweeps the whole RAM to all-used.
// Results wait in an output register, so the next item is taken while a result is still pending.
module bitmap_page_allocator #(
  parameter int NUM_PAGES = bpa_pkg::NUM_PAGES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration: page total
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [16:0] cfg_data,
  // Input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // run_length[16:0], page_index[32:17], zero pad
  input  logic [1:0]  s_axis_tuser,   // operation[1:0]
  // Result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // first_page[15:0], busy_pages[32:16], free_pages[49:33]
  output logic [1:0]  m_axis_tuser    // status[1:0]
);

  localparam int WB        = bpa_pkg::WORD_BITS;
  localparam int BW        = bpa_pkg::BIT_W;
  localparam int MAP_WORDS = (NUM_PAGES + WB - 1) / WB;
  localparam int WAW       = $clog2(MAP_WORDS);
  localparam int CW        = $clog2(NUM_PAGES + 1);
  localparam int XW0       = $clog2(MAP_WORDS * WB + 1);
  localparam int XW        = ((XW0 > 17) ? XW0 : 17) + 1;
  localparam logic [WB-1:0] ONES = '1;

  // Page map storage
  logic [WB-1:0]  mem [MAP_WORDS];
  logic [WB-1:0]  rd_data;
  logic [WAW-1:0] rd_addr;
  logic           wr_en;
  logic [WAW-1:0] wr_addr;
  logic [WB-1:0]  wr_data;

  bpa_pkg::state_t state, state_next;

  logic [16:0]    page_total;
  logic [CW-1:0]  used_count;
  logic [1:0]     op;
  logic [XW-1:0]  len;
  logic [15:0]    pg;
  logic [WAW-1:0] scan_w;
  logic [XW-1:0]  carry;
  logic [XW-1:0]  start;
  logic [XW-1:0]  end_page;
  logic [WAW-1:0] mark_w;
  logic [WAW-1:0] sweep_w;
  logic [1:0]     res_status;
  logic [15:0]    res_first;

  logic           accept;
  logic           out_load;
  logic [XW-1:0]  eff_total;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == bpa_pkg::ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state == bpa_pkg::ST_DONE) && (!m_axis_tvalid || m_axis_tready);

  // Saturate the configured total at the map capacity
  assign eff_total = (XW'(page_total) > XW'(NUM_PAGES)) ? XW'(NUM_PAGES) : XW'(page_total);

  // Scan of the word just read
  logic [XW-1:0]   base;
  logic            past_end;
  logic [XW-1:0]   lim;
  logic [WB-1:0]   vmask;
  logic [WB-1:0]   free_bits;
  logic [BW:0]     lead;
  logic [BW:0]     top;
  logic            spans;
  logic [WB-1:0]   hit;
  logic            int_hit;
  logic [BW-1:0]   hit_idx;
  logic            found;
  logic [XW-1:0]   found_start;
  logic            last_word;

  always_comb begin
    logic [6:0][WB-1:0] pw;
    logic [WB-1:0]      acc;
    int                 off;
    base      = XW'(scan_w) << BW;
    past_end  = base >= eff_total;
    lim       = eff_total - base;
    vmask     = (lim >= XW'(WB)) ? ONES : ~(ONES << lim[BW-1:0]);
    free_bits = ~rd_data & vmask;
    lead      = bpa_pkg::run_from_low(free_bits);
    top       = bpa_pkg::run_from_high(free_bits);
    spans     = (carry + XW'(lead)) >= len;
    // Runs of a power-of-two length starting at each bit
    pw[0] = free_bits;
    for (int k = 0; k < 6; k++) begin
      pw[k+1] = pw[k] & (pw[k] >> (1 << k));
    end
    // Combine them into runs of the requested length
    acc = ONES;
    off = 0;
    for (int k = 0; k < 7; k++) begin
      if (len[k]) begin
        acc = acc & (pw[k] >> off);
        off = off + (1 << k);
      end
    end
    hit         = (len <= XW'(WB)) ? acc : '0;
    int_hit     = |hit;
    hit_idx     = bpa_pkg::lowest_set(hit);
    found       = !past_end && (spans || int_hit);
    found_start = spans ? (base - carry) : (base + XW'(hit_idx));
    last_word   = (scan_w == WAW'(MAP_WORDS - 1));
  end

  // Mark mask for the word being written
  logic [WAW-1:0] start_w;
  logic [WAW-1:0] end_w;
  logic [BW-1:0]  lo_bit;
  logic [BW-1:0]  hi_bit;
  logic [WB-1:0]  mark_mask;

  assign start_w   = WAW'(start >> BW);
  assign end_w     = WAW'(end_page >> BW);
  assign lo_bit    = (mark_w == start_w) ? start[BW-1:0] : '0;
  assign hi_bit    = (mark_w == end_w) ? end_page[BW-1:0] : BW'(WB - 1);
  assign mark_mask = (ONES << lo_bit) & (ONES >> (BW'(WB - 1) - hi_bit));

  // Single-page access
  logic [WB-1:0] pg_mask;
  logic          pg_used;
  logic          pg_in_range;
  logic          single_ok;

  assign pg_mask     = WB'(1) << pg[BW-1:0];
  assign pg_used     = |(rd_data & pg_mask);
  assign pg_in_range = XW'(pg) < eff_total;
  assign single_ok   = pg_in_range && ((op == bpa_pkg::OP_FREE) ? pg_used : !pg_used);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      bpa_pkg::ST_CLEAR: begin
        if (sweep_w == WAW'(MAP_WORDS - 1)) state_next = bpa_pkg::ST_IDLE;
      end
      bpa_pkg::ST_IDLE: begin
        if (accept) begin
          case (s_axis_tuser)
            bpa_pkg::OP_ALLOC: begin
              state_next = (s_axis_tdata[16:0] == '0) ? bpa_pkg::ST_DONE : bpa_pkg::ST_SCAN;
            end
            bpa_pkg::OP_RESET: state_next = bpa_pkg::ST_FILL;
            default:           state_next = bpa_pkg::ST_SINGLE;
          endcase
        end
      end
      bpa_pkg::ST_SCAN: begin
        if (found) state_next = bpa_pkg::ST_MSTART;
        else if (past_end || last_word) state_next = bpa_pkg::ST_DONE;
      end
      bpa_pkg::ST_MSTART: state_next = bpa_pkg::ST_MARK;
      bpa_pkg::ST_MARK: begin
        if (mark_w == end_w) state_next = bpa_pkg::ST_DONE;
      end
      bpa_pkg::ST_SINGLE: state_next = bpa_pkg::ST_DONE;
      bpa_pkg::ST_FILL: begin
        if (sweep_w == WAW'(MAP_WORDS - 1)) state_next = bpa_pkg::ST_DONE;
      end
      bpa_pkg::ST_DONE: begin
        if (out_load) state_next = bpa_pkg::ST_IDLE;
      end
      default: state_next = bpa_pkg::ST_IDLE;
    endcase
  end

  // Memory port controls
  always_comb begin
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = sweep_w;
    wr_data = ONES;
    case (state)
      bpa_pkg::ST_CLEAR, bpa_pkg::ST_FILL: begin
        wr_en = 1'b1;
      end
      bpa_pkg::ST_IDLE: begin
        rd_addr = (s_axis_tuser == bpa_pkg::OP_ALLOC) ? '0 : WAW'(s_axis_tdata[32:17] >> BW);
      end
      bpa_pkg::ST_SCAN: rd_addr = WAW'(scan_w + 1'b1);
      bpa_pkg::ST_MSTART: rd_addr = mark_w;
      bpa_pkg::ST_MARK: begin
        rd_addr = WAW'(mark_w + 1'b1);
        wr_en   = 1'b1;
        wr_addr = mark_w;
        wr_data = rd_data | mark_mask;
      end
      bpa_pkg::ST_SINGLE: begin
        wr_en   = single_ok;
        wr_addr = WAW'(pg >> BW);
        wr_data = (op == bpa_pkg::OP_FREE) ? (rd_data & ~pg_mask) : (rd_data | pg_mask);
      end
      default: rd_addr = '0;
    endcase
  end

  // Map RAM: one read and one write port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  // State and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= bpa_pkg::ST_CLEAR;
      sweep_w       <= '0;
      used_count    <= CW'(NUM_PAGES);
      page_total    <= 17'(65536);
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) page_total <= cfg_data;
      if (out_load) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
      // Advance the sweep pointer
      if (state == bpa_pkg::ST_CLEAR || state == bpa_pkg::ST_FILL) sweep_w <= WAW'(sweep_w + 1'b1);
      else sweep_w <= '0;
      // Update the used count
      case (state)
        bpa_pkg::ST_FILL: begin
          if (sweep_w == WAW'(MAP_WORDS - 1)) used_count <= CW'(eff_total);
        end
        bpa_pkg::ST_MARK: begin
          if (mark_w == end_w) used_count <= CW'(XW'(used_count) + len);
        end
        bpa_pkg::ST_SINGLE: begin
          if (single_ok) begin
            if (op == bpa_pkg::OP_FREE) begin
              if (used_count != '0) used_count <= used_count - 1'b1;
            end else begin
              used_count <= used_count + 1'b1;
            end
          end
        end
        default: used_count <= used_count;
      endcase
    end
  end

  // Item fields, scan progress and pending result
  always_ff @(posedge clk) begin
    if (accept) begin
      op         <= s_axis_tuser;
      len        <= XW'(s_axis_tdata[16:0]);
      pg         <= s_axis_tdata[32:17];
      scan_w     <= '0;
      carry      <= '0;
      res_first  <= '0;
      res_status <= (s_axis_tuser == bpa_pkg::OP_ALLOC && s_axis_tdata[16:0] == '0) ?
                    bpa_pkg::STAT_BADLEN : bpa_pkg::STAT_DONE;
    end
    // Walk the map and carry the open run across words
    if (state == bpa_pkg::ST_SCAN) begin
      scan_w <= WAW'(scan_w + 1'b1);
      carry  <= (free_bits == ONES) ? (carry + XW'(WB)) : XW'(top);
      if (found) begin
        start     <= found_start;
        end_page  <= found_start + len - 1'b1;
        mark_w    <= WAW'(found_start >> BW);
        res_first <= found_start[15:0];
      end else if (past_end || last_word) begin
        res_status <= bpa_pkg::STAT_NOFIT;
      end
    end
    if (state == bpa_pkg::ST_MARK) mark_w <= WAW'(mark_w + 1'b1);
    if (state == bpa_pkg::ST_SINGLE && !single_ok) res_status <= bpa_pkg::STAT_NOCHANGE;
    // Load the output register
    if (out_load) begin
      m_axis_tuser         <= res_status;
      m_axis_tdata[15:0]   <= res_first;
      m_axis_tdata[32:16]  <= 17'(used_count);
      m_axis_tdata[49:33]  <= (eff_total > XW'(used_count)) ?
                              17'(eff_total - XW'(used_count)) : '0;
      m_axis_tdata[55:50]  <= '0;
    end
  end

endmodule

// ===== dv/bitmap_page_allocator_checker.sv =====
// Checker for the bitmap page allocator: watches both streams, predicts results, compares.
`timescale 1ns / 1ps
module bitmap_page_allocator_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [16:0] cfg_data,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [55:0] m_axis_tdata,
  input  logic [1:0]  m_axis_tuser,
  output int          mismatches,
  output int          pending
);

  localparam int PAGES = 65536;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] first_page;
    logic [16:0] busy_pages;
    logic [16:0] free_pages;
  } page_result_t;

  logic [PAGES-1:0] page_used;
  logic [16:0]      used_count;
  logic [16:0]      page_total;
  page_result_t     expected_results[$];

  // Work out one operation's result and update the page map copy.
  function automatic page_result_t allocate_predict(logic [1:0] op, logic [16:0] len,
                                                    logic [15:0] pg);
    page_result_t r;
    int total, run, start;
    bit found;
    r = '0;
    total = (page_total > PAGES) ? PAGES : page_total;
    r.status = bpa_pkg::STAT_DONE;
    case (op)
      bpa_pkg::OP_ALLOC: begin
        if (len == 0) begin
          r.status = bpa_pkg::STAT_BADLEN;
        end else begin
          run = 0;
          found = 0;
          start = 0;
          for (int p = 0; p < total; p++) begin
            if (page_used[p]) run = 0;
            else begin
              run++;
              if (run == len) begin
                start = p + 1 - len;
                found = 1;
                break;
              end
            end
          end
          if (found) begin
            for (int p = start; p < start + len; p++) page_used[p] = 1'b1;
            used_count = used_count + len;
            r.first_page = start[15:0];
          end else begin
            r.status = bpa_pkg::STAT_NOFIT;
          end
        end
      end
      bpa_pkg::OP_FREE: begin
        if (pg < total && page_used[pg]) begin
          page_used[pg] = 1'b0;
          if (used_count > 0) used_count--;
        end else begin
          r.status = bpa_pkg::STAT_NOCHANGE;
        end
      end
      bpa_pkg::OP_RESERVE: begin
        if (pg < total && !page_used[pg]) begin
          page_used[pg] = 1'b1;
          used_count++;
        end else begin
          r.status = bpa_pkg::STAT_NOCHANGE;
        end
      end
      default: begin
        page_used = '1;
        used_count = total[16:0];
      end
    endcase
    r.busy_pages = used_count;
    r.free_pages = (total > used_count) ? 17'(total - used_count) : 17'd0;
    return r;
  endfunction

  // Track configuration, predict on accepted inputs, compare accepted outputs.
  always @(posedge clk) begin
    page_result_t got, want;
    if (rst) begin
      page_used   <= '1;
      used_count  <= 17'd65536;
      page_total  <= 17'd65536;
      mismatches  <= 0;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) page_total = cfg_data;
      if (s_axis_tvalid && s_axis_tready)
        expected_results.push_back(allocate_predict(s_axis_tuser, s_axis_tdata[16:0],
                                                    s_axis_tdata[32:17]));
      if (m_axis_tvalid && m_axis_tready) begin
        got.status     = m_axis_tuser;
        got.first_page = m_axis_tdata[15:0];
        got.busy_pages = m_axis_tdata[32:16];
        got.free_pages = m_axis_tdata[49:33];
        if (expected_results.size() == 0) begin
          if (mismatches < 10) $display("unexpected result %p", got);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            if (mismatches < 10) $display("mismatch: expected %p actual %p", want, got);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
    pending <= expected_results.size();
  end

endmodule

// ===== dv/bitmap_page_allocator_tb.sv =====
// Testbench top for the bitmap page allocator: stimulus, idling and verdict.
`timescale 1ns / 1ps
module bitmap_page_allocator_tb;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [16:0] cfg_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [55:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  int          mismatches;
  int          pending;
  int          cycles;
  bit          hold_off;
  bit          steady;

  bitmap_page_allocator DUT (.*);

  bitmap_page_allocator_checker checker_i (.*);

  // Clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Timeout: bounds the whole run, allowing a full scan plus full mark per item plus stalls.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 10000000) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Result side: random stalls, quiet stretches, one long hold-off.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        m_axis_tready <= 1'b0;
        repeat (3000) @(posedge clk);
        hold_off = 0;
      end
      m_axis_tready <= steady || ($urandom_range(99) >= 24);
    end
  end

  // Write the page total while idle.
  task automatic write_total(input logic [16:0] value);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Offer one operation, with random gaps before it.
  task automatic send_op(input logic [1:0] op, input logic [16:0] len, input logic [15:0] pg);
    while (!steady && $urandom_range(99) < 24) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {7'd0, pg, len};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Wait for all results, then let a full map sweep pass.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
  endtask

  // Random operation biased toward in-range pages and short runs.
  task automatic random_op(input int total);
    int k;
    logic [16:0] len;
    logic [15:0] pg;
    k = $urandom_range(99);
    pg = (total > 0 && $urandom_range(9) != 0) ? 16'($urandom_range(total - 1))
                                              : 16'($urandom);
    if ($urandom_range(19) == 0) len = 17'($urandom);
    else len = 17'($urandom_range(12));
    if (k < 40) send_op(bpa_pkg::OP_ALLOC, len, pg);
    else if (k < 70) send_op(bpa_pkg::OP_FREE, len, pg);
    else if (k < 97) send_op(bpa_pkg::OP_RESERVE, len, pg);
    else send_op(bpa_pkg::OP_RESET, len, pg);
  endtask

  initial begin
    int totals[6];
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = bpa_pkg::OP_ALLOC;
    hold_off = 0;
    steady = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: default total, everything used at start.
    send_op(bpa_pkg::OP_ALLOC, 17'd1, 16'd0);
    send_op(bpa_pkg::OP_ALLOC, 17'd0, 16'd0);
    send_op(bpa_pkg::OP_FREE, 17'd0, 16'hFFFF);
    send_op(bpa_pkg::OP_FREE, 17'd0, 16'hFFFF);
    send_op(bpa_pkg::OP_FREE, 17'd0, 16'd0);
    send_op(bpa_pkg::OP_ALLOC, 17'h10000, 16'd0);
    send_op(bpa_pkg::OP_ALLOC, 17'h1FFFF, 16'd0);
    send_op(bpa_pkg::OP_ALLOC, 17'd1, 16'd0);
    send_op(bpa_pkg::OP_RESERVE, 17'd0, 16'hFFFF);
    send_op(bpa_pkg::OP_RESERVE, 17'd0, 16'hFFFF);
    drain();

    // Total of zero: nothing in range.
    write_total(17'd0);
    send_op(bpa_pkg::OP_ALLOC, 17'd1, 16'd0);
    send_op(bpa_pkg::OP_FREE, 17'd0, 16'd0);
    send_op(bpa_pkg::OP_RESERVE, 17'd0, 16'd0);
    send_op(bpa_pkg::OP_RESET, 17'd0, 16'd0);
    drain();

    // Total above capacity saturates; count to zero and below.
    write_total(17'h1FFFF);
    send_op(bpa_pkg::OP_RESET, 17'd0, 16'd0);
    drain();
    write_total(17'd2);
    send_op(bpa_pkg::OP_RESET, 17'd0, 16'd0);
    send_op(bpa_pkg::OP_FREE, 17'd0, 16'd0);
    send_op(bpa_pkg::OP_FREE, 17'd0, 16'd1);
    drain();
    write_total(17'd4);
    send_op(bpa_pkg::OP_FREE, 17'd0, 16'd2);
    send_op(bpa_pkg::OP_FREE, 17'd0, 16'd3);
    send_op(bpa_pkg::OP_ALLOC, 17'd3, 16'd0);
    send_op(bpa_pkg::OP_ALLOC, 17'd4, 16'd0);
    send_op(bpa_pkg::OP_RESERVE, 17'd0, 16'd1);
    drain();
    write_total(17'd1);
    send_op(bpa_pkg::OP_FREE, 17'd0, 16'd0);
    drain();

    // Random phases over several totals, one with a long result stall.
    totals = '{1, 64, 200, 700, 17'h1FFFF, 65536};
    foreach (totals[i]) begin
      write_total(17'(totals[i]));
      send_op(bpa_pkg::OP_RESET, 17'd0, 16'd0);
      for (int j = 0; j < 60; j++) begin
        if (j % 3 != 2) send_op(bpa_pkg::OP_FREE, 17'd0, 16'($urandom_range(
                                  totals[i] > 800 ? 799 : totals[i] - 1)));
        else random_op(totals[i] > 800 ? 800 : totals[i]);
      end
      for (int j = 0; j < 30; j++) random_op(totals[i] > 800 ? 800 : totals[i]);
      if (i == 2) begin
        hold_off = 1;
        steady = 1;
        for (int j = 0; j < 40; j++) random_op(200);
        steady = 0;
      end
      drain();
    end

    if (mismatches == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
